### rtl/ipfr_pkg.sv
// Shared types and constants for the IR pulse frame receiver.
package ipfr_pkg;

    localparam int BUF_BYTES_DEF = 1024;
    localparam int TIME_W        = 32;
    localparam int CFG_W         = 16;
    localparam int MAXLEN_W      = 10;
    localparam int IDX_W         = 10;
    localparam int CFG_IDX_W     = 3;
    localparam int IN_TDATA_W    = 32;
    localparam int OUT_TDATA_W   = 32;

    localparam logic [CFG_IDX_W-1:0] REG_HDR_MARK_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HDR_MARK_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HDR_SPACE_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HDR_SPACE_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_FLR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_THRESHOLD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MSG_BYTES = 3'd6;

    localparam logic OP_EDGE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef enum logic [1:0] {
        PH_HDR_MARK   = 2'd0,
        PH_HDR_SPACE  = 2'd1,
        PH_DATA_MARK  = 2'd2,
        PH_DATA_SPACE = 2'd3
    } phase_t;

    typedef struct packed {
        logic [CFG_W-1:0]    hdr_mark_min;
        logic [CFG_W-1:0]    hdr_mark_max;
        logic [CFG_W-1:0]    hdr_space_min;
        logic [CFG_W-1:0]    hdr_space_max;
        logic [CFG_W-1:0]    interval_floor;
        logic [CFG_W-1:0]    one_threshold;
        logic [MAXLEN_W-1:0] max_message_bytes;
    } cfg_t;

    // receiver state apart from the byte counter and the edge time
    typedef struct packed {
        phase_t     phase;
        logic [7:0] bit_shift;
        logic [2:0] bit_count;
        logic [7:0] block_byte;
        logic [7:0] remainder_byte;
    } rx_state_t;

    // result item, last field in the lowest bits
    typedef struct packed {
        logic             overflow;
        logic             was_reset;
        logic             size_bad;
        logic             message_ready;
        logic             receiving;
        logic [IDX_W-1:0] byte_index;
        logic [7:0]       byte_value;
        logic             byte_valid;
        phase_t           phase;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

### rtl/ipfr_decode.sv
// Single-pass edge decode: next receiver state and result item.
module ipfr_decode #(
    parameter int BUF_BYTES = ipfr_pkg::BUF_BYTES_DEF,
    parameter int CNT_W     = $clog2(BUF_BYTES + 1)
) (
    input  ipfr_pkg::cfg_t                cfg,
    input  logic                          opcode,
    input  logic [ipfr_pkg::TIME_W-1:0]   edge_time,
    input  ipfr_pkg::rx_state_t           st,
    input  logic [CNT_W-1:0]              byte_count,
    input  logic [ipfr_pkg::TIME_W-1:0]   last_edge_time,
    output ipfr_pkg::rx_state_t           st_next,
    output logic [CNT_W-1:0]              byte_count_next,
    output logic [ipfr_pkg::TIME_W-1:0]   last_edge_time_next,
    output ipfr_pkg::result_t             res
);

    localparam int CMP_W = (CNT_W > 15) ? CNT_W : 15;

    logic [ipfr_pkg::TIME_W-1:0] diff;
    logic                        rst;
    logic                        bit_in;
    logic [7:0]                  shifted;
    logic [2:0]                  bc_inc;
    logic                        buf_full;
    logic [7:0]                  blk_m1;
    logic [13:0]                 total;
    logic                        recv;
    logic                        bad;
    ipfr_pkg::result_t           res_core;

    assign diff     = edge_time - last_edge_time;
    assign bit_in   = diff > ipfr_pkg::TIME_W'(cfg.one_threshold);
    assign shifted  = {st.bit_shift[6:0], bit_in};
    assign bc_inc   = st.bit_count + 3'd1;
    assign buf_full = byte_count >= CNT_W'(BUF_BYTES);

    always_comb begin
        st_next             = st;
        byte_count_next     = byte_count;
        last_edge_time_next = edge_time;
        rst                 = 1'b0;
        res_core            = '0;
        if (opcode == ipfr_pkg::OP_RESTART) begin
            last_edge_time_next = '0;
            rst                 = 1'b1;
        end else if (last_edge_time == '0 || last_edge_time > edge_time) begin
            rst = 1'b1;
        end else if ((diff > ipfr_pkg::TIME_W'(cfg.hdr_mark_max) &&
                      (st.phase == ipfr_pkg::PH_HDR_MARK ||
                       st.phase == ipfr_pkg::PH_HDR_SPACE)) ||
                     diff < ipfr_pkg::TIME_W'(cfg.interval_floor)) begin
            rst = 1'b1;
        end else begin
            case (st.phase)
                ipfr_pkg::PH_HDR_MARK: begin
                    if (diff >= ipfr_pkg::TIME_W'(cfg.hdr_mark_min))
                        st_next.phase = ipfr_pkg::PH_HDR_SPACE;
                    else
                        rst = 1'b1;
                end
                ipfr_pkg::PH_HDR_SPACE: begin
                    if (diff >= ipfr_pkg::TIME_W'(cfg.hdr_space_min) &&
                        diff <= ipfr_pkg::TIME_W'(cfg.hdr_space_max))
                        st_next.phase = ipfr_pkg::PH_DATA_MARK;
                    else
                        rst = 1'b1;
                end
                ipfr_pkg::PH_DATA_MARK: begin
                    st_next.phase     = ipfr_pkg::PH_DATA_SPACE;
                    st_next.bit_shift = shifted;
                    st_next.bit_count = bc_inc;
                    if (bc_inc == 3'd0) begin
                        st_next.bit_shift = '0;
                        if (buf_full) begin
                            res_core.overflow = 1'b1;
                        end else begin
                            res_core.byte_valid = 1'b1;
                            res_core.byte_value = shifted;
                            res_core.byte_index = ipfr_pkg::IDX_W'(byte_count);
                            byte_count_next     = byte_count + CNT_W'(1);
                            if (byte_count == '0)
                                st_next.block_byte = shifted;
                            else if (byte_count == CNT_W'(1))
                                st_next.remainder_byte = shifted;
                        end
                    end
                end
                ipfr_pkg::PH_DATA_SPACE: st_next.phase = ipfr_pkg::PH_DATA_MARK;
                default: st_next.phase = ipfr_pkg::PH_HDR_MARK;
            endcase
        end
        if (rst) begin
            st_next         = '0;
            byte_count_next = '0;
            res_core        = '0;
        end
        res_core.was_reset = rst;
        res_core.phase     = st_next.phase;
    end

    // length = (blocks - 1) * 32 + remainder
    assign blk_m1 = st_next.block_byte - 8'd1;
    assign total  = {1'b0, blk_m1, 5'b0} + {6'b0, st_next.remainder_byte};
    assign recv   = byte_count_next > CNT_W'(2);
    assign bad    = st_next.block_byte == '0 || total == '0 ||
                    total > {4'b0, cfg.max_message_bytes};

    always_comb begin
        res               = res_core;
        res.receiving     = recv;
        res.size_bad      = recv && bad;
        res.message_ready = recv && !bad &&
                            (CMP_W'(byte_count_next) >= CMP_W'(total) + CMP_W'(2));
    end

endmodule

### rtl/ir_pulse_frame_receiver_top.sv
// IR pulse frame receiver: input register, decode, result register, config.
// Takes one item per clock unless a result waits on m_tready: an item is
// registered in the input register, then decoded in a single pass into the
// result register, which drives m_tvalid. While a result waits on m_tready,
// the input register holds its item and s_tready is low once it is full.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wr_data; the user
// must write it only while idle, as the block does not enforce this.
module ir_pulse_frame_receiver_top #(
    parameter int BUF_BYTES = ipfr_pkg::BUF_BYTES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [ipfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ipfr_pkg::CFG_W-1:0]        cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ipfr_pkg::IN_TDATA_W-1:0]   s_tdata,   // edge_time
    input  logic                              s_tuser,   // opcode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // phase, byte_valid, byte_value, byte_index, receiving, message_ready,
    // size_bad, was_reset, overflow, zero fill
    output logic [ipfr_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    localparam int CNT_W = $clog2(BUF_BYTES + 1);

    ipfr_pkg::cfg_t              cfg_reg;
    logic                        in_valid_reg;
    logic                        in_op_reg;
    logic [ipfr_pkg::TIME_W-1:0] in_time_reg;
    ipfr_pkg::rx_state_t         st_reg, st_next;
    logic [CNT_W-1:0]            byte_count_reg, byte_count_next;
    logic [ipfr_pkg::TIME_W-1:0] last_edge_reg, last_edge_next;
    ipfr_pkg::result_t           res_reg, res_next;
    logic                        out_valid_reg;
    logic                        adv;

    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(ipfr_pkg::OUT_TDATA_W - ipfr_pkg::RESULT_W){1'b0}}, res_reg};

    ipfr_decode #(
        .BUF_BYTES (BUF_BYTES),
        .CNT_W     (CNT_W)
    ) u_decode (
        .cfg                 (cfg_reg),
        .opcode              (in_op_reg),
        .edge_time           (in_time_reg),
        .st                  (st_reg),
        .byte_count          (byte_count_reg),
        .last_edge_time      (last_edge_reg),
        .st_next             (st_next),
        .byte_count_next     (byte_count_next),
        .last_edge_time_next (last_edge_next),
        .res                 (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hdr_mark_min      <= 16'd2000;
            cfg_reg.hdr_mark_max      <= 16'd4000;
            cfg_reg.hdr_space_min     <= 16'd1000;
            cfg_reg.hdr_space_max     <= 16'd2000;
            cfg_reg.interval_floor    <= 16'd100;
            cfg_reg.one_threshold     <= 16'd600;
            cfg_reg.max_message_bytes <= 10'd1022;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ipfr_pkg::REG_HDR_MARK_MIN:  cfg_reg.hdr_mark_min   <= cfg_wr_data;
                ipfr_pkg::REG_HDR_MARK_MAX:  cfg_reg.hdr_mark_max   <= cfg_wr_data;
                ipfr_pkg::REG_HDR_SPACE_MIN: cfg_reg.hdr_space_min  <= cfg_wr_data;
                ipfr_pkg::REG_HDR_SPACE_MAX: cfg_reg.hdr_space_max  <= cfg_wr_data;
                ipfr_pkg::REG_INTERVAL_FLR:  cfg_reg.interval_floor <= cfg_wr_data;
                ipfr_pkg::REG_ONE_THRESHOLD: cfg_reg.one_threshold  <= cfg_wr_data;
                ipfr_pkg::REG_MAX_MSG_BYTES:
                    cfg_reg.max_message_bytes <= cfg_wr_data[ipfr_pkg::MAXLEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            st_reg         <= '0;
            byte_count_reg <= '0;
            last_edge_reg  <= '0;
        end else begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (adv) begin
                st_reg         <= st_next;
                byte_count_reg <= byte_count_next;
                last_edge_reg  <= last_edge_next;
                out_valid_reg  <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= s_tuser;
            in_time_reg <= s_tdata;
        end
        if (adv)
            res_reg <= res_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= CNT_W'(BUF_BYTES))
        else $error("byte counter beyond buffer size");

    a_byte_xor_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(res_reg.byte_valid && res_reg.overflow))
        else $error("byte stored and dropped at once");

    a_reset_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && res_next.was_reset |=>
            st_reg.phase == ipfr_pkg::PH_HDR_MARK && byte_count_reg == '0)
        else $error("receiver reset left state behind");

    a_restart_time: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && in_op_reg == ipfr_pkg::OP_RESTART |=> last_edge_reg == '0)
        else $error("restart kept edge time");

    a_ready_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(res_reg.message_ready && res_reg.size_bad))
        else $error("message ready with bad size");

endmodule

### verif/ir_pulse_frame_receiver_top_test.sv
// Self-checking testbench for the IR pulse frame receiver: predicted decode of every edge item.
module ir_pulse_frame_receiver_top_test;
    import ipfr_pkg::*;

    localparam int BUF_BYTES   = BUF_BYTES_DEF;
    localparam int QUIET_LIMIT = 5000;

    class ir_decode_scoreboard;
        logic [CFG_W-1:0]    hdr_mark_min, hdr_mark_max, hdr_space_min, hdr_space_max;
        logic [CFG_W-1:0]    floor_us, one_us;
        logic [MAXLEN_W-1:0] max_len;

        phase_t      rx_phase;
        logic [31:0] last_us;
        logic [7:0]  shift_reg;
        logic [2:0]  nbits;
        logic [10:0] nbytes;
        logic [7:0]  blk, rem;

        result_t decode_q[$];
        int      errors;

        function new();
            hdr_mark_min  = 16'd2000;
            hdr_mark_max  = 16'd4000;
            hdr_space_min = 16'd1000;
            hdr_space_max = 16'd2000;
            floor_us      = 16'd100;
            one_us        = 16'd600;
            max_len       = 10'd1022;
            last_us       = '0;
            errors        = 0;
            clear_rx();
        endfunction

        function void clear_rx();
            rx_phase  = PH_HDR_MARK;
            shift_reg = '0;
            nbits     = '0;
            nbytes    = '0;
            blk       = '0;
            rem       = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_HDR_MARK_MIN:  hdr_mark_min  = val;
                REG_HDR_MARK_MAX:  hdr_mark_max  = val;
                REG_HDR_SPACE_MIN: hdr_space_min = val;
                REG_HDR_SPACE_MAX: hdr_space_max = val;
                REG_INTERVAL_FLR:  floor_us      = val;
                REG_ONE_THRESHOLD: one_us        = val;
                REG_MAX_MSG_BYTES: max_len       = val[MAXLEN_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_item(logic op, logic [31:0] t);
            result_t     r;
            logic [31:0] diff;
            logic        bit_v;
            int          total;
            r = '0;
            if (op == OP_RESTART) begin
                last_us = '0;
                clear_rx();
                r.was_reset = 1'b1;
            end else if (last_us == 0 || last_us > t) begin
                last_us = t;
                clear_rx();
                r.was_reset = 1'b1;
            end else begin
                diff = t - last_us;
                last_us = t;
                if ((diff > hdr_mark_max &&
                     (rx_phase == PH_HDR_MARK || rx_phase == PH_HDR_SPACE)) ||
                    diff < floor_us) begin
                    r.was_reset = 1'b1;
                end else begin
                    case (rx_phase)
                        PH_HDR_MARK: begin
                            if (diff >= hdr_mark_min && diff <= hdr_mark_max)
                                rx_phase = PH_HDR_SPACE;
                            else
                                r.was_reset = 1'b1;
                        end
                        PH_HDR_SPACE: begin
                            if (diff >= hdr_space_min && diff <= hdr_space_max)
                                rx_phase = PH_DATA_MARK;
                            else
                                r.was_reset = 1'b1;
                        end
                        PH_DATA_MARK: begin
                            bit_v = (diff > one_us);
                            shift_reg = {shift_reg[6:0], bit_v};
                            nbits = nbits + 3'd1;
                            if (nbits == 0) begin
                                if (nbytes >= BUF_BYTES) begin
                                    r.overflow = 1'b1;
                                end else begin
                                    r.byte_valid = 1'b1;
                                    r.byte_value = shift_reg;
                                    r.byte_index = nbytes[IDX_W-1:0];
                                    if (nbytes == 0) blk = shift_reg;
                                    else if (nbytes == 1) rem = shift_reg;
                                    nbytes = nbytes + 11'd1;
                                end
                                shift_reg = '0;
                            end
                            rx_phase = PH_DATA_SPACE;
                        end
                        default: rx_phase = PH_DATA_MARK;
                    endcase
                end
                if (r.was_reset) clear_rx();
            end

            r.receiving = (nbytes > 2);
            if (r.receiving) begin
                total = (int'(blk) - 1) * 32 + int'(rem);
                if (blk == 0 || total == 0 || total > int'(max_len))
                    r.size_bad = 1'b1;
                else
                    r.message_ready = (int'(nbytes) >= total + 2);
            end
            r.phase = rx_phase;
            decode_q.push_back(r);
        endfunction

        function void cmp_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_item(logic [OUT_TDATA_W-1:0] tdata);
            result_t got, want;
            got = result_t'(tdata[RESULT_W-1:0]);
            if (decode_q.size() == 0) begin
                $error("result item with nothing expected: %h", tdata);
                errors++;
                return;
            end
            want = decode_q.pop_front();
            cmp_field("phase", want.phase, got.phase);
            cmp_field("byte_valid", want.byte_valid, got.byte_valid);
            cmp_field("byte_value", want.byte_value, got.byte_value);
            cmp_field("byte_index", want.byte_index, got.byte_index);
            cmp_field("receiving", want.receiving, got.receiving);
            cmp_field("message_ready", want.message_ready, got.message_ready);
            cmp_field("size_bad", want.size_bad, got.size_bad);
            cmp_field("was_reset", want.was_reset, got.was_reset);
            cmp_field("overflow", want.overflow, got.overflow);
        endfunction

        function int pending();
            return decode_q.size();
        endfunction

        function void flag_leftover();
            if (decode_q.size() != 0) begin
                $error("%0d expected result items never arrived", decode_q.size());
                errors += decode_q.size();
            end
        endfunction
    endclass

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index   = '0;
    logic [CFG_W-1:0]       cfg_wr_data = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata     = '0;   // edge_time
    logic                   s_tuser     = 1'b0; // opcode
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;            // result_t fields, phase lowest

    ir_decode_scoreboard sb;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          items_sent    = 0;
    int          quiet_cycles  = 0;
    logic [31:0] now_us        = '0;

    ir_pulse_frame_receiver_top #(.BUF_BYTES(BUF_BYTES)) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_item(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick(logic [31:0] lo, logic [31:0] hi);
        if (hi <= lo) return lo;
        case ($urandom_range(3))
            0: return lo;
            1: return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    task automatic send_item(input logic op, input logic [31:0] t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= t;
        do @(posedge aclk); while (!s_tready);
        sb.note_item(op, t);
        if (op == OP_EDGE) now_us = t;
        items_sent++;
    endtask

    task automatic send_edge(input logic [31:0] diff);
        send_item(OP_EDGE, now_us + diff);
    endtask

    // hold the sender until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    task automatic load_regs(input logic [CFG_W-1:0] hm_lo, hm_hi, hs_lo, hs_hi,
                             input logic [CFG_W-1:0] floor_v, one_v,
                             input logic [MAXLEN_W-1:0] len_max);
        set_reg(REG_HDR_MARK_MIN, hm_lo);
        set_reg(REG_HDR_MARK_MAX, hm_hi);
        set_reg(REG_HDR_SPACE_MIN, hs_lo);
        set_reg(REG_HDR_SPACE_MAX, hs_hi);
        set_reg(REG_INTERVAL_FLR, floor_v);
        set_reg(REG_ONE_THRESHOLD, one_v);
        set_reg(REG_MAX_MSG_BYTES, CFG_W'(len_max));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_noise();
        case ($urandom_range(3))
            0: send_item(OP_RESTART, $urandom);
            1: send_edge(pick(0, 70000));
            2: send_item(OP_EDGE, $urandom);
            default: send_edge(pick(0, sb.floor_us));
        endcase
    endtask

    task automatic send_frame(input logic [7:0] blocks, rem, input int n_payload,
                              input bit noisy);
        logic [7:0]  val;
        logic [31:0] hm_lo, hs_lo, hs_hi, t0;
        hm_lo = (sb.hdr_mark_min > sb.floor_us) ? sb.hdr_mark_min : sb.floor_us;
        hs_lo = (sb.hdr_space_min > sb.floor_us) ? sb.hdr_space_min : sb.floor_us;
        hs_hi = (sb.hdr_space_max < sb.hdr_mark_max) ? sb.hdr_space_max : sb.hdr_mark_max;
        if ($urandom_range(3) == 0) send_item(OP_EDGE, 32'd0);
        else send_item(OP_RESTART, $urandom);
        if ($urandom_range(15) == 0) t0 = $urandom_range(32'hFFFF_FFFF, 32'hFFF0_0000);
        else t0 = $urandom_range(32'hEFFF_FFFF, 1);
        send_item(OP_EDGE, t0);
        send_edge(pick(hm_lo, sb.hdr_mark_max));
        send_edge(pick(hs_lo, hs_hi));
        for (int i = 0; i < n_payload + 2; i++) begin
            val = (i == 0) ? blocks : (i == 1) ? rem : 8'($urandom_range(255));
            for (int b = 7; b >= 0; b--) begin
                if (noisy && $urandom_range(999) < 3) send_noise();
                if (val[b]) send_edge(pick(sb.one_us + 1, sb.one_us + 3001));
                else send_edge(pick(sb.floor_us, sb.one_us));
                send_edge(pick(sb.floor_us, sb.floor_us + 2000));
            end
        end
    endtask

    task automatic send_random_frame();
        int         cap, len, n;
        logic [7:0] b, r;
        if ($urandom_range(9) < 7) begin
            cap = (sb.max_len < 6) ? int'(sb.max_len) : 6;
            if ($urandom_range(7) == 0) cap = (sb.max_len < 40) ? int'(sb.max_len) : 40;
            len = $urandom_range(cap, 1);
            if ($urandom_range(1)) begin
                b = 8'd1;
                r = 8'(len);
            end else begin
                b = 8'((len - 1) / 32 + 1);
                r = 8'(len - (int'(b) - 1) * 32);
            end
            n = len;
            case ($urandom_range(5))
                0: n = len - 1;
                1: n = len + $urandom_range(2);
                default: ;
            endcase
        end else begin
            b = 8'($urandom_range(255));
            r = 8'($urandom_range(255));
            case ($urandom_range(2))
                0: b = 8'd0;
                1: begin
                    b = 8'd1;
                    r = 8'd0;
                end
                default: ;
            endcase
            n = $urandom_range(5);
        end
        send_frame(b, r, n, 1'b1);
    endtask

    task automatic run_random(input int n_items);
        int start;
        start = items_sent;
        while (items_sent - start < n_items) send_random_frame();
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset register values
        send_idle_pct = 32;
        recv_idle_pct = 56;
        send_item(OP_RESTART, 32'hFFFF_FFFF);
        send_item(OP_EDGE, 32'hFFFF_FFFF);  // no previous edge
        send_item(OP_EDGE, 32'd1000);       // time went backwards
        send_item(OP_EDGE, 32'd0);
        send_item(OP_EDGE, 32'd500);
        send_edge(99);                      // below floor
        send_edge(4001);                    // header mark too long
        send_edge(1999);                    // header mark too short
        send_edge(2000);
        send_edge(999);                     // header space too short
        send_edge(4000);
        send_edge(2001);                    // header space too long
        send_edge(3000);
        send_edge(2000);
        send_edge(600);                     // zero bit at threshold
        send_edge(100);
        send_edge(601);
        send_edge(65535);
        send_edge(70000);                   // long data mark is legal
        send_edge(5000);
        send_edge(50);                      // floor violation mid byte
        send_item(OP_RESTART, 32'd0);
        drain();

        load_regs(16'd500, 16'd900, 16'd300, 16'd500, 16'd50, 16'd200, 10'd40);
        run_random(150);
        drain();

        load_regs(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 10'd1);
        send_idle_pct = 56;
        recv_idle_pct = 32;
        run_random(75);
        drain();

        load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd1022);
        run_random(75);
        drain();

        load_regs(16'd2000, 16'd4000, 16'd1000, 16'd2000, 16'd100, 16'd600, 10'd1022);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(150);
        drain();

        repeat (8) @(posedge aclk);
        sb.flag_leftover();
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### files.f
rtl/ipfr_pkg.sv
rtl/ipfr_decode.sv
rtl/ir_pulse_frame_receiver_top.sv
verif/ir_pulse_frame_receiver_top_test.sv
